/* rtl/amc_pkg.sv */
// amc_pkg: shared widths, command codes and defaults for the address map cache
// used by address_map_cache_unit; no dependencies
`default_nettype none

package amc_pkg;

  localparam int unsigned AMC_ENTRIES = 32;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 5;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

/* rtl/amc_ram.sv */
// amc_ram: generic single-port synchronous ram, one write or read per cycle,
// registered read data; no dependencies
`default_nettype none

module amc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   addr_i,
  input  wire logic [Width-1:0]           wdata_i,
  output logic      [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/address_map_cache_unit.sv */
// address_map_cache_unit: fully associative ipv4 to mac cache, oldest-stamp replacement
// depends on amc_pkg and amc_ram
//
// usage: drive command_i, ip_addr_i and mac_in_i and raise start; the transaction
// is taken at the edge where start is high and busy is low. busy stays high
// while the transaction is worked on. the result (hit_o, mac_out_o, slot_o) is shown
// for exactly one cycle with done_o high; the receiver cannot hold it off, and a new
// transaction may be started in that same cycle.
// key, mac and stamp of an entry share one word of a single-port ram.
// a transaction reads the filled entries one per cycle; the registered read delays the
// last compare, after which the scan state hands over to the write-back cycle, which also
// loads the result register; the scan over the ram port sets the length of a transaction.
// entries are never invalidated and a new key always takes the lowest free entry,
// so the valid entries are exactly those below a fill count.
// reset clears the fill count, the stamp counter and the control state; ram contents
// are not cleared and need no clearing pass.
`default_nettype none

module address_map_cache_unit
  import amc_pkg::*;
#(
  parameter int unsigned ENTRIES = AMC_ENTRIES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command_i,
  input  wire logic [IP_W-1:0]    ip_addr_i,
  input  wire logic [MAC_W-1:0]   mac_in_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic      [MAC_W-1:0]   mac_out_o,
  output logic      [SLOT_W-1:0]  slot_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned EntryW = IP_W + MAC_W + STAMP_W;
  localparam logic [CntW-1:0] FillMax = CntW'(ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [STAMP_W-1:0] counter_q, counter_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]    rd_idx_q, rd_idx_d;

  logic               cmd_q;
  logic [IP_W-1:0]    ip_q;
  logic [MAC_W-1:0]   mac_q;

  logic               found_q, found_d;
  logic [IdxW-1:0]    found_idx_q, found_idx_d;
  logic [MAC_W-1:0]   found_mac_q, found_mac_d;
  logic [STAMP_W-1:0] min_q, min_d;
  logic [IdxW-1:0]    min_idx_q, min_idx_d;

  logic               done_q, done_d;
  logic               hit_q, hit_d;
  logic [MAC_W-1:0]   mac_out_q, mac_out_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;

  logic               issue;
  logic               full;
  logic [IdxW-1:0]    target;
  logic [IdxW-1:0]    ram_addr;
  logic               ram_we;
  logic [EntryW-1:0]  ram_rd;
  logic [IP_W-1:0]    key_rd;
  logic [MAC_W-1:0]   val_rd;
  logic [STAMP_W-1:0] stamp_rd;

  assign full  = (fill_q == FillMax);
  assign issue = (state_q == ST_SCAN) && (idx_q != fill_q);

  // a found key wins, else the lowest free entry, else the oldest stamp
  always_comb begin
    if (found_q) begin
      target = found_idx_q;
    end else if (!full) begin
      target = fill_q[IdxW-1:0];
    end else begin
      target = min_idx_q;
    end
  end

  assign ram_we   = (state_q == ST_FINISH) && (cmd_e'(cmd_q) == CMD_ADD);
  assign ram_addr = (state_q == ST_FINISH) ? target : idx_q[IdxW-1:0];

  amc_ram #(.Width(EntryW), .Depth(ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({ip_q, mac_q, counter_q}),
    .rdata_o (ram_rd)
  );

  assign {key_rd, val_rd, stamp_rd} = ram_rd;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    counter_d   = counter_q;
    idx_d       = idx_q;
    rd_vld_d    = issue;
    rd_idx_d    = idx_q[IdxW-1:0];
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_mac_d = found_mac_q;
    min_d       = min_q;
    min_idx_d   = min_idx_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    mac_out_d   = mac_out_q;
    slot_d      = slot_q;

    // read data of the previous cycle's entry
    if (rd_vld_q) begin
      if (!found_q && key_rd == ip_q) begin
        found_d     = 1'b1;
        found_idx_d = rd_idx_q;
        found_mac_d = val_rd;
      end
      if (rd_idx_q == '0 || stamp_rd < min_q) begin
        min_d     = stamp_rd;
        min_idx_d = rd_idx_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        done_d  = 1'b1;
        hit_d   = found_q;
        state_d = ST_IDLE;
        if (cmd_e'(cmd_q) == CMD_LOOKUP) begin
          mac_out_d = found_q ? found_mac_q : '0;
          slot_d    = found_q ? SLOT_W'(found_idx_q) : '0;
        end else begin
          mac_out_d = '0;
          slot_d    = SLOT_W'(target);
          counter_d = counter_q + 1'b1;
          if (!found_q && !full) begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      counter_q <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      counter_q <= counter_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      cmd_q <= command_i;
      ip_q  <= ip_addr_i;
      mac_q <= mac_in_i;
    end
    rd_idx_q    <= rd_idx_d;
    found_idx_q <= found_idx_d;
    found_mac_q <= found_mac_d;
    min_q       <= min_d;
    min_idx_q   <= min_idx_d;
    hit_q       <= hit_d;
    mac_out_q   <= mac_out_d;
    slot_q      <= slot_d;
  end

  assign busy      = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign hit_o     = hit_q;
  assign mac_out_o = mac_out_q;
  assign slot_o    = slot_q;

  // a result only follows the write-back cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == ST_FINISH)
    else $error("result without a finished transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count beyond table size");

  // the scan never reads past the filled entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q <= fill_q)
    else $error("scan index beyond fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

`default_nettype wire
